// ===== src/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared widths, command codes and parameter defaults for the lowest common
// ancestor core.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int unsigned MAX_NODES_DEF   = 65536;
    localparam int unsigned LIFT_LEVELS_DEF = 16;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned DEPTH_W = 16;

    localparam logic CMD_ATTACH = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage

// ===== src/tlca_ram.sv =====
// ----------------------------------------------------------------------------
// tlca_ram
// Synchronous RAM, one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tlca_ram #(
    parameter int unsigned AW = 1,
    parameter int unsigned DW = tlca_pkg::ID_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== src/tree_lca_binary_lifting_core.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_core
// Binary-lifting ancestor table and depth store with attach and common
// ancestor query requests.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An attach takes one depth read, then a
// read and a write of the ancestor table per level above level 0. A query
// lifts the deeper node by the depth gap, then climbs both nodes, and each
// lifting and climbing step waits on one registered ancestor table read. A
// finished result waits in the output register while the next request is
// taken. Node 0, and node 1 until it is attached, read as all zero, so no
// clearing pass runs after reset. Nodes must be attached parent-first.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_core #(
    parameter int unsigned MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
    parameter int unsigned LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // node_a [15:0], node_b [31:16]
    input  logic [0:0]  s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ancestor [15:0]
);

    localparam int unsigned ID_W    = tlca_pkg::ID_W;
    localparam int unsigned DEPTH_W = tlca_pkg::DEPTH_W;
    localparam int unsigned NODE_W  = (MAX_NODES >= (1 << ID_W)) ? ID_W : $clog2(MAX_NODES);
    localparam int unsigned LVW     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int unsigned LCW     = $clog2(LIFT_LEVELS + 1);
    localparam int unsigned TAB_AW  = NODE_W + LVW;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_ATT_DEP = 12'b0000_0000_0010,
        ST_ATT_RD  = 12'b0000_0000_0100,
        ST_ATT_WR  = 12'b0000_0000_1000,
        ST_Q_DEP   = 12'b0000_0001_0000,
        ST_LIFT    = 12'b0000_0010_0000,
        ST_LIFT_WR = 12'b0000_0100_0000,
        ST_CHECK   = 12'b0000_1000_0000,
        ST_CL_RD   = 12'b0001_0000_0000,
        ST_CL_CMP  = 12'b0010_0000_0000,
        ST_FIN     = 12'b0100_0000_0000,
        ST_OUT     = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ID_W-1:0]     x_reg, x_next;
    logic [ID_W-1:0]     y_reg, y_next;
    logic [DEPTH_W-1:0]  gap_reg, gap_next;
    logic [LCW-1:0]      lvl_reg, lvl_next;
    logic                lift_y_reg, lift_y_next;
    logic [ID_W-1:0]     ans_reg, ans_next;
    logic                root_seen_reg, root_seen_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_data_reg, out_data_next;

    logic [ID_W-1:0]     in_a_id, in_b_id;
    logic                in_cmd;
    logic                in_accept;

    logic                tab_we;
    logic [TAB_AW-1:0]   tab_waddr;
    logic [ID_W-1:0]     tab_wdata;
    logic [ID_W-1:0]     tab_rd_node_a, tab_rd_node_b;
    logic [LVW-1:0]      tab_rd_lvl_a, tab_rd_lvl_b;
    logic [ID_W-1:0]     tab_q_a, tab_q_b;
    logic                tab_blank_a_reg, tab_blank_b_reg;
    logic [ID_W-1:0]     tab_a, tab_b;

    logic                dep_we;
    logic [NODE_W-1:0]   dep_waddr;
    logic [DEPTH_W-1:0]  dep_wdata;
    logic [DEPTH_W-1:0]  dep_q_a, dep_q_b;
    logic                dep_blank_a_reg, dep_blank_b_reg;
    logic [DEPTH_W-1:0]  dep_a, dep_b;

    logic [LCW-1:0]      lvl_m1;
    logic [ID_W-1:0]     lift_node;
    logic [DEPTH_W-1:0]  gap_ab, gap_ba;

    function automatic logic is_blank(input logic [ID_W-1:0] n, input logic root_seen);
        return (n == '0) || ((n == ID_W'(1)) && !root_seen);
    endfunction

    assign in_a_id   = (32'(s_tdata[15:0]) < MAX_NODES) ? s_tdata[15:0] : '0;
    assign in_b_id   = (32'(s_tdata[31:16]) < MAX_NODES) ? s_tdata[31:16] : '0;
    assign in_cmd    = s_tuser[0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign lvl_m1    = lvl_reg - LCW'(1);
    assign lift_node = lift_y_reg ? y_reg : x_reg;
    assign tab_a     = tab_blank_a_reg ? '0 : tab_q_a;
    assign tab_b     = tab_blank_b_reg ? '0 : tab_q_b;
    assign dep_a     = dep_blank_a_reg ? '0 : dep_q_a;
    assign dep_b     = dep_blank_b_reg ? '0 : dep_q_b;
    assign gap_ab    = dep_a - dep_b;
    assign gap_ba    = dep_b - dep_a;

    tlca_ram #(
        .AW (TAB_AW),
        .DW (ID_W)
    ) u_tab_ram (
        .aclk      (aclk),
        .wr_en     (tab_we),
        .wr_addr   (tab_waddr),
        .wr_data   (tab_wdata),
        .rd_addr_a ({tab_rd_node_a[NODE_W-1:0], tab_rd_lvl_a}),
        .rd_addr_b ({tab_rd_node_b[NODE_W-1:0], tab_rd_lvl_b}),
        .rd_data_a (tab_q_a),
        .rd_data_b (tab_q_b)
    );

    tlca_ram #(
        .AW (NODE_W),
        .DW (DEPTH_W)
    ) u_dep_ram (
        .aclk      (aclk),
        .wr_en     (dep_we),
        .wr_addr   (dep_waddr),
        .wr_data   (dep_wdata),
        .rd_addr_a (in_a_id[NODE_W-1:0]),
        .rd_addr_b (in_b_id[NODE_W-1:0]),
        .rd_data_a (dep_q_a),
        .rd_data_b (dep_q_b)
    );

    always_comb begin
        tab_rd_node_a = x_reg;
        tab_rd_node_b = y_reg;
        tab_rd_lvl_a  = '0;
        tab_rd_lvl_b  = '0;
        unique case (state_reg)
            ST_ATT_RD: begin
                tab_rd_node_a = y_reg;
                tab_rd_lvl_a  = lvl_m1[LVW-1:0];
            end
            ST_LIFT: begin
                tab_rd_node_a = lift_node;
                tab_rd_lvl_a  = lvl_reg[LVW-1:0];
            end
            ST_CL_RD: begin
                if (lvl_reg != '0) begin
                    tab_rd_lvl_a = lvl_m1[LVW-1:0];
                    tab_rd_lvl_b = lvl_m1[LVW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        gap_next       = gap_reg;
        lvl_next       = lvl_reg;
        lift_y_next    = lift_y_reg;
        ans_next       = ans_reg;
        root_seen_next = root_seen_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        tab_we         = 1'b0;
        tab_waddr      = {x_reg[NODE_W-1:0], lvl_reg[LVW-1:0]};
        tab_wdata      = tab_a;
        dep_we         = 1'b0;
        dep_waddr      = x_reg[NODE_W-1:0];
        dep_wdata      = (y_reg == '0) ? '0 : dep_b + DEPTH_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    x_next = in_a_id;
                    y_next = in_b_id;
                    if (in_cmd == tlca_pkg::CMD_QUERY) begin
                        state_next = ST_Q_DEP;
                    end else if (in_a_id != '0) begin
                        state_next = ST_ATT_DEP;
                    end
                end
            end
            ST_ATT_DEP: begin
                dep_we    = 1'b1;
                tab_we    = 1'b1;
                tab_waddr = {x_reg[NODE_W-1:0], LVW'(0)};
                tab_wdata = y_reg;
                if (x_reg == ID_W'(1)) begin
                    root_seen_next = 1'b1;
                end
                lvl_next   = LCW'(1);
                state_next = (LIFT_LEVELS == 1) ? ST_IDLE : ST_ATT_RD;
            end
            ST_ATT_RD: begin
                state_next = ST_ATT_WR;
            end
            ST_ATT_WR: begin
                tab_we = 1'b1;
                y_next = tab_a;
                if (lvl_reg == LCW'(LIFT_LEVELS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next   = lvl_reg + LCW'(1);
                    state_next = ST_ATT_RD;
                end
            end
            ST_Q_DEP: begin
                lvl_next    = '0;
                lift_y_next = (dep_b > dep_a);
                gap_next    = (dep_b > dep_a) ? gap_ba : gap_ab;
                if ((gap_next >> LIFT_LEVELS) != '0) begin
                    ans_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LIFT;
                end
            end
            ST_LIFT: begin
                if (gap_reg == '0) begin
                    state_next = ST_CHECK;
                end else if (gap_reg[0]) begin
                    state_next = ST_LIFT_WR;
                end else begin
                    gap_next = gap_reg >> 1;
                    lvl_next = lvl_reg + LCW'(1);
                end
            end
            ST_LIFT_WR: begin
                if (lift_y_reg) begin
                    y_next = tab_a;
                end else begin
                    x_next = tab_a;
                end
                gap_next   = gap_reg >> 1;
                lvl_next   = lvl_reg + LCW'(1);
                state_next = ST_LIFT;
            end
            ST_CHECK: begin
                if ((x_reg == '0) || (y_reg == '0)) begin
                    ans_next   = '0;
                    state_next = ST_OUT;
                end else if (x_reg == y_reg) begin
                    ans_next   = x_reg;
                    state_next = ST_OUT;
                end else begin
                    lvl_next   = LCW'(LIFT_LEVELS);
                    state_next = ST_CL_RD;
                end
            end
            ST_CL_RD: begin
                state_next = (lvl_reg == '0) ? ST_FIN : ST_CL_CMP;
            end
            ST_CL_CMP: begin
                if (tab_a != tab_b) begin
                    x_next = tab_a;
                    y_next = tab_b;
                end
                lvl_next   = lvl_m1;
                state_next = ST_CL_RD;
            end
            ST_FIN: begin
                ans_next   = tab_a;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = ans_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            root_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            root_seen_reg <= root_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg           <= x_next;
        y_reg           <= y_next;
        gap_reg         <= gap_next;
        lvl_reg         <= lvl_next;
        lift_y_reg      <= lift_y_next;
        ans_reg         <= ans_next;
        out_data_reg    <= out_data_next;
        tab_blank_a_reg <= is_blank(tab_rd_node_a, root_seen_reg);
        tab_blank_b_reg <= is_blank(tab_rd_node_b, root_seen_reg);
        dep_blank_a_reg <= is_blank(in_a_id, root_seen_reg);
        dep_blank_b_reg <= is_blank(in_b_id, root_seen_reg);
    end

endmodule

// ===== tb/tb_tree_lca_binary_lifting_core.sv =====
// ----------------------------------------------------------------------------
// tb_tree_lca_binary_lifting_core
// Self-checking bench for the binary-lifting common ancestor core. Attach and
// query requests go in over the slave stream; every query answer from the
// master stream is matched in order against a directed row's answer or an
// ancestor-table model. A short directed table runs first, then random
// parent-first forests, under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_tree_lca_binary_lifting_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS         = tlca_pkg::LIFT_LEVELS_DEF;
    localparam int PHASE_ITEMS    = 510;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int DIRECTED_COUNT = 23;

    typedef struct packed {
        logic        cmd;
        logic [15:0] node_a;
        logic [15:0] node_b;
        logic        known;
        logic [15:0] answer;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // node_a [15:0], node_b [31:16]
    logic [0:0]  s_tuser  = '0;   // cmd [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // ancestor [15:0]

    // model state
    logic [15:0] anc_rows [int];
    bit   [15:0] node_depth [65536];
    logic [15:0] expected_ancestors [$];

    // stimulus bookkeeping
    logic [15:0] loaded_nodes [$];
    bit          is_loaded [int];
    logic [15:0] last_loaded = 16'd1;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  hold_left     = 0;
    bit  pressure_armed = 1'b0;
    logic [15:0] want;

    dir_row_t directed_rows [DIRECTED_COUNT] = '{
        '{tlca_pkg::CMD_QUERY,  16'd0,     16'd0,     1'b1, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd1,     16'd1,     1'b1, 16'd1},
        '{tlca_pkg::CMD_QUERY,  16'd1,     16'd0,     1'b1, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd0,     16'd1,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd0,     16'd1,     1'b1, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd2,     16'd1,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd3,     16'd2,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd65535, 16'd3,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd32768, 16'd2,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65535, 16'd32768, 1'b1, 16'd2},
        '{tlca_pkg::CMD_QUERY,  16'd32768, 16'd65535, 1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65535, 16'd3,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65535, 16'd65535, 1'b1, 16'd65535},
        '{tlca_pkg::CMD_ATTACH, 16'd4,     16'd0,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd5,     16'd4,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd5,     16'd65535, 1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd4,     16'd5,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65535, 16'd0,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd1,     16'd0,     1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd3,     16'd3,     1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65535, 16'd32768, 1'b0, 16'd0},
        '{tlca_pkg::CMD_ATTACH, 16'd65534, 16'd65535, 1'b0, 16'd0},
        '{tlca_pkg::CMD_QUERY,  16'd65534, 16'd2,     1'b0, 16'd0}
    };

    tree_lca_binary_lifting_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // ancestor table model
    // ------------------------------------------------------------------
    function automatic logic [15:0] row_of(logic [15:0] n, int lvl);
        int key;
        key = int'(n) * LEVELS + lvl;
        return anc_rows.exists(key) ? anc_rows[key] : 16'd0;
    endfunction

    function automatic void attach_node(logic [15:0] a, logic [15:0] b);
        logic [15:0] cur;
        if (a == 16'd0)
            return;
        node_depth[a] = (b == 16'd0) ? 16'd0 : node_depth[b] + 16'd1;
        anc_rows[int'(a) * LEVELS] = b;
        cur = b;
        for (int lvl = 1; lvl < LEVELS; lvl++) begin
            if (cur != 16'd0)
                cur = row_of(cur, lvl - 1);
            anc_rows[int'(a) * LEVELS + lvl] = cur;
        end
    endfunction

    function automatic logic [15:0] lift_by(logic [15:0] n, int unsigned gap);
        logic [15:0] cur;
        cur = n;
        for (int lvl = 0; lvl < LEVELS; lvl++)
            if (gap[lvl])
                cur = row_of(cur, lvl);
        return cur;
    endfunction

    function automatic logic [15:0] lca_of(logic [15:0] u_in, logic [15:0] v_in);
        logic [15:0] u, v, au, av;
        int unsigned gap;
        u = u_in;
        v = v_in;
        if (node_depth[u] > node_depth[v]) begin
            gap = node_depth[u] - node_depth[v];
            if ((gap >> LEVELS) != 0)
                return 16'd0;
            u = lift_by(u, gap);
        end else if (node_depth[v] > node_depth[u]) begin
            gap = node_depth[v] - node_depth[u];
            if ((gap >> LEVELS) != 0)
                return 16'd0;
            v = lift_by(v, gap);
        end
        if (u == 16'd0 || v == 16'd0)
            return 16'd0;
        if (u == v)
            return u;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            au = row_of(u, i);
            av = row_of(v, i);
            if (au != av) begin
                u = au;
                v = av;
            end
        end
        return row_of(u, 0);
    endfunction

    // ------------------------------------------------------------------
    // request driver, called at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [15:0] a, input logic [15:0] b,
                                input logic known, input logic [15:0] answer);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd == tlca_pkg::CMD_QUERY) begin
            expected_ancestors.insert(expected_ancestors.size(),
                                      known ? answer : lca_of(a, b));
        end else begin
            attach_node(a, b);
            if (a != 16'd0) begin
                if (!is_loaded.exists(int'(a))) begin
                    is_loaded[int'(a)] = 1'b1;
                    loaded_nodes.insert(loaded_nodes.size(), a);
                end
                last_loaded = a;
            end
        end
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_loaded();
        int n;
        n = loaded_nodes.size();
        if (n == 0 || $urandom_range(99) < 5)
            return 16'($urandom_range(1));
        if ($urandom_range(99) < 40)
            return loaded_nodes[n - 1 - $urandom_range((n < 16) ? n - 1 : 15)];
        return loaded_nodes[$urandom_range(n - 1)];
    endfunction

    task automatic random_request();
        logic [15:0] a, b;
        int p;
        if ($urandom_range(99) < 45) begin
            if (loaded_nodes.size() > 0 && $urandom_range(99) < 12)
                a = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
            else
                a = 16'($urandom_range(65535));
            // parent must already be loaded, or be node 0 / node 1
            p = $urandom_range(99);
            if (p < 5)
                b = 16'd0;
            else if (p < 12 || loaded_nodes.size() == 0)
                b = 16'd1;
            else if (p < 65)
                b = last_loaded;
            else
                b = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
            send_request(tlca_pkg::CMD_ATTACH, a, b, 1'b0, 16'd0);
        end else begin
            a = pick_loaded();
            p = $urandom_range(99);
            if (p < 20)
                b = row_of(a, $urandom_range(LEVELS - 1));
            else if (p < 28)
                b = a;
            else if (p < 35)
                b = 16'($urandom_range(1));
            else
                b = pick_loaded();
            if ($urandom_range(1))
                send_request(tlca_pkg::CMD_QUERY, a, b, 1'b0, 16'd0);
            else
                send_request(tlca_pkg::CMD_QUERY, b, a, 1'b0, 16'd0);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (pressure_armed) begin
            pressure_armed = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_ancestors.size() == 0) begin
                    report_mismatch($sformatf("unexpected result ancestor=%0d", m_tdata));
                end else begin
                    want = expected_ancestors.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("ancestor got %0d want %0d", m_tdata, want));
                end
            end
        end
    end

    initial begin
        @(posedge aresetn);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("tb_tree_lca_binary_lifting_core: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 8;
        recv_idle_pct = 87;
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].node_a,
                         directed_rows[i].node_b, directed_rows[i].known,
                         directed_rows[i].answer);
        repeat (PHASE_ITEMS) random_request();

        send_idle_pct = 87;
        recv_idle_pct = 8;
        repeat (PHASE_ITEMS) random_request();

        // no idling; a long output stall backs the core up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_armed = 1'b1;
        repeat (PHASE_ITEMS) random_request();

        s_tvalid <= 1'b0;
        while (expected_ancestors.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("tb_tree_lca_binary_lifting_core: PASS");
        else
            $display("tb_tree_lca_binary_lifting_core: FAIL");
        $finish;
    end

endmodule
